@@ rtl/core/pld_pkg.sv @@
// ----------------------------------------------------------------------------
// pld_pkg
// Shared types, register codes, reset values and helpers for the
// pseudo-log / derivative block.
// ----------------------------------------------------------------------------
package pld_pkg;

  // fixed point format of samples and results
  localparam int unsigned FracBits = 24;
  localparam int unsigned WideW    = 128;
  localparam int unsigned ExpW     = 6;
  localparam int unsigned SampW    = 32;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned IterW    = 5;
  localparam int unsigned LnShift  = 32;

  // ln(2) in unsigned Q0.32
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;

  localparam logic signed [63:0] S64Max = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64Min = {1'b1, {63{1'b0}}};

  // register reset values
  localparam logic signed [63:0] OneHalfFix  = 64'sd3 <<< (FracBits - 1);
  localparam logic signed [63:0] HalfFix     = 64'sd1 <<< (FracBits - 1);
  localparam logic [24:0]        ThreshRst   = 25'd1 << FracBits;
  localparam logic signed [28:0] LogOffRst   = 29'(-OneHalfFix);
  localparam logic [41:0]        LinCoefRst  = 42'd2 << FracBits;
  localparam logic signed [55:0] QuadCoefRst = 56'(-HalfFix);

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD    = 8'd0,
    REG_LOG_OFFSET   = 8'd1,
    REG_LINEAR_COEFF = 8'd2,
    REG_QUAD_COEFF   = 8'd3
  } reg_idx_e;

  typedef struct packed {
    logic [24:0]        threshold;
    logic signed [28:0] log_offset;
    logic [41:0]        linear_coeff;
    logic signed [55:0] quad_coeff;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [63:0] first_deriv;
    logic signed [63:0] root_neg_second;
    logic signed [63:0] running_total;
    logic               last_out;
  } out_rsp_t;

  // shared unit operations
  typedef enum logic {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } unit_op_e;

  typedef struct packed {
    unit_op_e           op;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } unit_req_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_NEG,
    U_DIV,
    U_DONE
  } unit_state_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_T1,
    S_LIN,
    S_SQ,
    S_T2,
    S_DIV,
    S_NORM,
    S_SQR,
    S_LN,
    S_ACC
  } seq_state_e;

  // clamp a wide signed value to the signed 64-bit range
  function automatic logic signed [63:0] sat64(input logic signed [WideW-1:0] v);
    logic signed [63:0] r;
    if (v[WideW-1:63] == {(WideW-63){v[63]}}) begin
      r = v[63:0];
    end else if (v[WideW-1]) begin
      r = S64Min;
    end else begin
      r = S64Max;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/pld_cfg.sv @@
// ----------------------------------------------------------------------------
// pld_cfg
// Coefficient registers, written through the configuration request channel.
// ----------------------------------------------------------------------------
module pld_cfg import pld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_i,
  input  logic [CfgIdxW-1:0] index_i,
  input  logic [63:0]        data_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  // decode the written register
  always_comb begin
    cfg_d = cfg_q;
    if (wr_i) begin
      case (index_i)
        REG_THRESHOLD:    cfg_d.threshold    = data_i[24:0];
        REG_LOG_OFFSET:   cfg_d.log_offset   = data_i[28:0];
        REG_LINEAR_COEFF: cfg_d.linear_coeff = data_i[41:0];
        REG_QUAD_COEFF:   cfg_d.quad_coeff   = data_i[55:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= ThreshRst;
      cfg_q.log_offset   <= LogOffRst;
      cfg_q.linear_coeff <= LinCoefRst;
      cfg_q.quad_coeff   <= QuadCoefRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/core/pld_unit.sv @@
// ----------------------------------------------------------------------------
// pld_unit
// Shared iterative arithmetic unit: shift-add signed multiply, one multiplier
// bit per cycle, and restoring divide of 2^(2F) by a positive value, one
// quotient bit per cycle. Both run on the same 128-bit accumulator.
// ----------------------------------------------------------------------------
module pld_unit import pld_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  unit_req_t               req_i,
  output logic                    done_o,
  output logic signed [WideW-1:0] result_o
);

  localparam int unsigned DivSteps = 2 * FracBits;

  unit_state_e state_q, state_d;

  logic signed [WideW-1:0] acc_q, a_q;
  logic [63:0]             b_q;
  logic                    neg_q;
  logic [31:0]             rem_q;
  logic [DivCntW-1:0]      cnt_q;

  logic [32:0] trial;
  logic        q_bit;

  // restoring divide step
  assign trial = {rem_q, b_q[DivSteps]};
  assign q_bit = (trial >= {1'b0, a_q[31:0]});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          state_d = (req_i.op == OP_DIV) ? U_DIV : U_MUL;
        end
      end
      U_MUL: begin
        if (b_q == '0) begin
          state_d = neg_q ? U_NEG : U_DONE;
        end
      end
      U_NEG:   state_d = U_DONE;
      U_DIV: begin
        if (cnt_q == '0) begin
          state_d = U_DONE;
        end
      end
      U_DONE:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    done_o   = (state_q == U_DONE);
    result_o = acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // accumulator datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      U_IDLE: begin
        if (start_i) begin
          acc_q <= '0;
          rem_q <= '0;
          cnt_q <= DivCntW'(DivSteps);
          if (req_i.op == OP_DIV) begin
            a_q   <= {{(WideW-32){1'b0}}, req_i.b[31:0]};
            b_q   <= 64'd1 << DivSteps;
            neg_q <= 1'b0;
          end else begin
            a_q   <= WideW'(req_i.a);
            b_q   <= req_i.b[63] ? 64'(-req_i.b) : req_i.b;
            neg_q <= req_i.b[63];
          end
        end
      end
      U_MUL: begin
        if (b_q != '0) begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q <= a_q <<< 1;
          b_q <= b_q >> 1;
        end
      end
      U_NEG: acc_q <= -acc_q;
      U_DIV: begin
        rem_q <= q_bit ? 32'(trial - {1'b0, a_q[31:0]}) : trial[31:0];
        acc_q <= {acc_q[WideW-2:0], q_bit};
        b_q   <= b_q << 1;
        cnt_q <= cnt_q - 1'b1;
      end
      default: acc_q <= acc_q;
    endcase
  end

  // checks
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == U_IDLE) else $error("unit started while busy");
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && req_i.op == OP_DIV) |-> req_i.b[31:0] != '0)
    else $error("divide by zero requested");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held longer than one cycle");

endmodule

@@ rtl/core/pseudo_log_sum_derivatives.sv @@
// ----------------------------------------------------------------------------
// pseudo_log_sum_derivatives
// Pseudo-logarithm with derivatives and a running per-set sum, built around
// one shared iterative multiply/divide unit under a small sequencer.
// ----------------------------------------------------------------------------
//  channel  signals                          direction  moves
//  in       in_valid_i/in_ready_o/in_req_i   in         sample, last_in
//  out      out_valid_o/out_ready_i/out_rsp_o out       derivatives, total
//  cfg      cfg_valid_i/cfg_ready_o/idx/data in         one coefficient
//
//  quadratic branch: four shift-add multiplies on the shared unit.
//  log branch: one divide, a normalize shift loop, F squarings and one
//  ln(2) multiply; in_ready_o is high only when the sequencer is idle.
//  a finished result sits in the output register, so a stalled output
//  delays the block only when the next result is ready to be written.
//  reset clears the sequencer and the running sum and loads the coefficient reset values.
// ----------------------------------------------------------------------------
module pseudo_log_sum_derivatives import pld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_req_t            in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_rsp_t           out_rsp_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [63:0]        cfg_data_i
);

  localparam int unsigned MantW = FracBits + 1;
  localparam int unsigned SqW   = FracBits + 2;

  cfg_t cfg;
  seq_state_e state_q, state_d;

  logic signed [SampW-1:0] x_q;
  logic                    last_q;
  logic signed [63:0]      d1_q, root_q, val_q, sum_q;
  logic signed [WideW-1:0] w_q;
  logic [63:0]             sq_q;
  logic [SampW-1:0]        norm_q;
  logic [IterW-1:0]        k_q, it_q;
  logic [MantW-1:0]        m_q;
  logic [FracBits-1:0]     frac_q;
  logic                    issued_q;
  out_rsp_t                out_q;
  logic                    out_valid_q;

  logic                    unit_start, unit_done;
  unit_req_t               unit_req;
  logic signed [WideW-1:0] prod, prod_shf, prod_ln;
  logic [SqW-1:0]          sq_t;
  logic signed [ExpW-1:0]  exp_part;
  logic signed [ExpW+FracBits-1:0] log2v;
  logic                    in_fire, out_free, is_quad;
  logic signed [63:0]      sum_next;

  assign cfg_ready_o = 1'b1;

  pld_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (cfg_valid_i),
    .index_i (cfg_index_i),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  pld_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (unit_start),
    .req_i    (unit_req),
    .done_o   (unit_done),
    .result_o (prod)
  );

  // product scaling and log helpers
  assign prod_shf = prod >>> FracBits;
  assign prod_ln  = prod >>> LnShift;
  assign sq_t     = prod[FracBits +: SqW];
  assign exp_part = ExpW'({1'b0, k_q}) - ExpW'(FracBits);
  assign log2v    = {exp_part, frac_q};

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign is_quad  = in_req_i.sample[SampW-1] ||
                    (in_req_i.sample < $signed({7'b0, cfg.threshold}));
  assign sum_next = sat64(WideW'(sum_q) + WideW'(val_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (is_quad) begin
            state_d = S_T1;
          end else if (in_req_i.sample == '0) begin
            state_d = S_ACC;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_T1:  if (unit_done) state_d = S_LIN;
      S_LIN: if (unit_done) state_d = S_SQ;
      S_SQ:  if (unit_done) state_d = S_T2;
      S_T2:  if (unit_done) state_d = S_ACC;
      S_DIV: if (unit_done) state_d = S_NORM;
      S_NORM: if (norm_q[SampW-1]) state_d = S_SQR;
      S_SQR: begin
        if (unit_done && it_q == IterW'(FracBits - 1)) begin
          state_d = S_LN;
        end
      end
      S_LN:  if (unit_done) state_d = S_ACC;
      S_ACC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs and unit operands
  always_comb begin
    in_ready_o = (state_q == S_IDLE);
    unit_start = (state_q inside {S_T1, S_LIN, S_SQ, S_T2, S_DIV, S_SQR, S_LN}) &&
                 !issued_q;
    unit_req.op = OP_MUL;
    unit_req.a  = '0;
    unit_req.b  = '0;
    case (state_q)
      S_T1: begin
        unit_req.a = 64'(cfg.quad_coeff);
        unit_req.b = 64'(x_q);
      end
      S_LIN: begin
        unit_req.a = {22'b0, cfg.linear_coeff};
        unit_req.b = 64'(x_q);
      end
      S_SQ: begin
        unit_req.a = 64'(x_q);
        unit_req.b = 64'(x_q);
      end
      S_T2: begin
        unit_req.a = 64'(cfg.quad_coeff);
        unit_req.b = sq_q;
      end
      S_DIV: begin
        unit_req.op = OP_DIV;
        unit_req.b  = 64'(x_q);
      end
      S_SQR: begin
        unit_req.a = {{(64-MantW){1'b0}}, m_q};
        unit_req.b = {{(64-MantW){1'b0}}, m_q};
      end
      S_LN: begin
        unit_req.a = 64'(log2v);
        unit_req.b = {32'b0, Ln2Q32};
      end
      default: unit_req.op = OP_MUL;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      sum_q       <= '0;
    end else begin
      state_q <= state_d;
      if (unit_start) begin
        issued_q <= 1'b1;
      end else if (unit_done) begin
        issued_q <= 1'b0;
      end
      if (state_q == S_ACC && out_free) begin
        out_valid_q <= 1'b1;
        sum_q       <= last_q ? '0 : sum_next;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          x_q    <= in_req_i.sample;
          last_q <= in_req_i.last_in;
          d1_q   <= S64Max;
          root_q <= S64Max;
          val_q  <= S64Min;
        end
      end
      S_T1: begin
        if (unit_done) begin
          d1_q   <= sat64(WideW'(cfg.linear_coeff) + (prod_shf <<< 1));
          root_q <= {23'b0, cfg.linear_coeff[41:1]};
        end
      end
      S_LIN: if (unit_done) w_q <= WideW'(cfg.log_offset) + prod_shf;
      S_SQ:  if (unit_done) sq_q <= prod_shf[63:0];
      S_T2:  if (unit_done) val_q <= sat64(w_q + prod_shf);
      S_DIV: begin
        if (unit_done) begin
          d1_q   <= prod[63:0];
          root_q <= prod[63:0];
          norm_q <= x_q;
          k_q    <= IterW'(SampW - 1);
        end
      end
      S_NORM: begin
        if (norm_q[SampW-1]) begin
          m_q    <= norm_q[SampW-1 -: MantW];
          frac_q <= '0;
          it_q   <= '0;
        end else begin
          norm_q <= norm_q << 1;
          k_q    <= k_q - 1'b1;
        end
      end
      S_SQR: begin
        if (unit_done) begin
          m_q    <= sq_t[SqW-1] ? sq_t[SqW-1:1] : sq_t[MantW-1:0];
          frac_q <= {frac_q[FracBits-2:0], sq_t[SqW-1]};
          it_q   <= it_q + 1'b1;
        end
      end
      S_LN: if (unit_done) val_q <= prod_ln[63:0];
      S_ACC: begin
        if (out_free) begin
          out_q.first_deriv     <= d1_q;
          out_q.root_neg_second <= root_q;
          out_q.running_total   <= sum_next;
          out_q.last_out        <= last_q;
        end
      end
      default: x_q <= x_q;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC && out_free && last_q) |=> sum_q == '0)
    else $error("running sum not cleared after last request");
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> issued_q) else $error("unit finished without a start");
  a_idle_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !issued_q) else $error("accepting while unit busy");

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pseudo_log_sum_derivatives. Drives samples with
// random gaps, stalls the result side at random and compares each result
// against a bit-exact predictor. The predictor covers the quadratic branch,
// the log branch and the running set sum over several coefficient settings.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pld_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned DrainCycles = 1000;

  // bit-exact pseudo-log predictor and queue of pending results
  class pld_scoreboard;
    logic [24:0]        thr;
    logic signed [28:0] offs;
    logic [41:0]        lin_c;
    logic signed [55:0] quad_c;
    logic signed [63:0] set_sum;
    out_rsp_t           pending_q[$];
    int                 errors;

    function new();
      thr     = ThreshRst;
      offs    = LogOffRst;
      lin_c   = LinCoefRst;
      quad_c  = QuadCoefRst;
      set_sum = '0;
      errors  = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [63:0] d);
      case (idx)
        REG_THRESHOLD:    thr    = d[24:0];
        REG_LOG_OFFSET:   offs   = d[28:0];
        REG_LINEAR_COEFF: lin_c  = d[41:0];
        REG_QUAD_COEFF:   quad_c = d[55:0];
        default: ;
      endcase
    endfunction

    // clamp to the signed 64-bit range
    function logic signed [63:0] clamp64(logic signed [127:0] v);
      logic signed [63:0] r;
      if (v > 128'sh7FFF_FFFF_FFFF_FFFF) begin
        r = S64Max;
      end else if (v < -128'sh8000_0000_0000_0000) begin
        r = S64Min;
      end else begin
        r = v[63:0];
      end
      return r;
    endfunction

    // natural log of a positive value through log2 by repeated squaring
    function logic signed [63:0] nat_log(logic [63:0] v);
      int                  k;
      logic [63:0]         mant;
      logic [63:0]         frac;
      logic signed [63:0]  log2v;
      logic signed [127:0] prod;
      k = 0;
      frac = '0;
      for (int i = 0; i < 64; i++) begin
        if (v[i]) k = i;
      end
      if (k >= FracBits) mant = v >> (k - FracBits);
      else mant = v << (FracBits - k);
      for (int i = 0; i < FracBits; i++) begin
        mant = (mant * mant) >> FracBits;
        frac = frac << 1;
        if (mant >= (64'd2 << FracBits)) begin
          mant = mant >> 1;
          frac[0] = 1'b1;
        end
      end
      log2v = (longint'(k) - longint'(FracBits)) * (longint'(1) << FracBits)
              + longint'(frac);
      prod = log2v;
      prod = (prod * 128'sd2977044472) >>> LnShift;
      return clamp64(prod);
    endfunction

    // work out the result of one accepted request
    function void note_request(in_req_t req);
      logic signed [127:0] xw, a2w, a3w, t1, lw, sq, t2, val;
      logic signed [63:0]  value;
      out_rsp_t            rsp;
      xw  = req.sample;
      a2w = {86'b0, lin_c};
      a3w = quad_c;
      if (req.sample < 0 || xw < $signed({103'b0, thr})) begin
        t1  = (a3w * xw) >>> FracBits;
        lw  = (a2w * xw) >>> FracBits;
        sq  = (xw * xw) >>> FracBits;
        t2  = (a3w * sq) >>> FracBits;
        rsp.first_deriv     = clamp64(a2w + t1 + t1);
        rsp.root_neg_second = {23'b0, lin_c[41:1]};
        val = $signed(offs);
        value = clamp64(val + lw + t2);
      end else if (req.sample == 0) begin
        rsp.first_deriv     = S64Max;
        rsp.root_neg_second = S64Max;
        value               = S64Min;
      end else begin
        rsp.first_deriv     = (64'd1 << (2 * FracBits)) / {32'b0, req.sample};
        rsp.root_neg_second = rsp.first_deriv;
        value               = nat_log({32'b0, req.sample});
      end
      set_sum = clamp64(128'(set_sum) + 128'(value));
      rsp.running_total = set_sum;
      rsp.last_out      = req.last_in;
      if (req.last_in) set_sum = '0;
      pending_q.push_back(rsp);
    endfunction

    // compare one result with the oldest prediction
    function void check_result(out_rsp_t got);
      out_rsp_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.first_deriv !== exp_r.first_deriv) begin
        $error("first_deriv exp %0d got %0d", exp_r.first_deriv, got.first_deriv);
        errors++;
      end
      if (got.root_neg_second !== exp_r.root_neg_second) begin
        $error("root_neg_second exp %0d got %0d", exp_r.root_neg_second,
               got.root_neg_second);
        errors++;
      end
      if (got.running_total !== exp_r.running_total) begin
        $error("running_total exp %0d got %0d", exp_r.running_total,
               got.running_total);
        errors++;
      end
      if (got.last_out !== exp_r.last_out) begin
        $error("last_out exp %0d got %0d", exp_r.last_out, got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_req_t            in_req_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_rsp_t           out_rsp_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [63:0]        cfg_data_i = '0;

  pld_scoreboard sb = new();
  bit            no_stall = 1'b0;
  bit            no_gap = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   quiet_cycles = 0;

  always #2 clk_i = ~clk_i;

  pseudo_log_sum_derivatives DUT (.*);

  // result side: random stalls, check on every handshake
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      sb.check_result(out_rsp_o);
      stall_left = no_stall ? 0 : $urandom_range(0, 8);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni;
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [63:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, d);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  // one request, with a random gap before it
  task automatic send_sample(logic signed [31:0] x, logic last);
    int unsigned gap;
    in_req_t     req;
    gap = no_gap ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.sample  = x;
    req.last_in = last;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(req);
  endtask

  // random sample biased around the switch point
  function automatic logic signed [31:0] draw_sample();
    logic signed [31:0] x;
    case ($urandom_range(0, 5))
      0:       x = $urandom;
      1:       x = -$signed({1'b0, 30'($urandom_range(0, 32'h0400_0000))});
      2:       x = $urandom_range(0, 32'h0200_0000);
      3:       x = $signed({7'b0, sb.thr}) + $signed($urandom_range(0, 8)) - 4;
      4:       x = $urandom_range(0, 255);
      default: x = $urandom_range(32'h0100_0000, 32'h7FFF_FFFF);
    endcase
    return x;
  endfunction

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      send_sample(draw_sample(), ($urandom_range(0, 7) == 0));
      if (i == n / 2 && $urandom_range(0, 1)) begin
        // hold off until the block has emptied
        in_valid_i <= 1'b0;
        drain();
      end
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes and branch edges at reset settings
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(-32'sd1, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    send_sample(32'sh0100_0000, 1'b0);
    send_sample(32'sh00FF_FFFF, 1'b0);
    send_sample(32'sh5555_5555, 1'b0);
    send_sample(32'shAAAA_AAAA, 1'b1);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh8000_0000, 1'b1);
    in_valid_i <= 1'b0;
    drain();

    // zero threshold: zero skips the quadratic branch and saturates the sum low
    write_reg(REG_THRESHOLD, 64'd0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(32'sh0100_0000, 1'b1);
    send_sample(-32'sd5, 1'b1);
    random_items(120);
    drain();

    // extreme coefficients for large n
    write_reg(REG_THRESHOLD, 64'd1);
    write_reg(REG_LOG_OFFSET, 64'hFFFF_FFFF_F000_0000);
    write_reg(REG_LINEAR_COEFF, 64'h200_0000_0000);
    write_reg(REG_QUAD_COEFF, 64'hFF80_0000_0000_0000);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh7FFF_FFFF, 1'b0);
    send_sample(32'sd0, 1'b1);
    no_stall = 1'b1;
    no_gap = 1'b1;
    random_items(150);
    drain();
    no_stall = 1'b0;
    no_gap = 1'b0;

    // other extremes of every register
    write_reg(REG_THRESHOLD, 64'h100_0000);
    write_reg(REG_LOG_OFFSET, 64'd0);
    write_reg(REG_LINEAR_COEFF, 64'd0);
    write_reg(REG_QUAD_COEFF, 64'd0);
    random_items(150);
    drain();

    // random coefficient sets
    for (int p = 0; p < 5; p++) begin
      write_reg(REG_THRESHOLD, $urandom_range(0, 32'h0100_0000));
      write_reg(REG_LOG_OFFSET, -longint'($urandom_range(0, 32'h1000_0000)));
      write_reg(REG_LINEAR_COEFF, {$urandom, $urandom} & 64'h3FF_FFFF_FFFF
                >> $urandom_range(0, 30));
      write_reg(REG_QUAD_COEFF, -longint'(({$urandom, $urandom} & 64'h7F_FFFF_FFFF_FFFF)
                >> $urandom_range(0, 40)));
      no_stall = (p == 2);
      random_items(160);
      drain();
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ pseudo_log_sum_derivatives.f @@
rtl/core/pld_pkg.sv
rtl/core/pld_cfg.sv
rtl/core/pld_unit.sv
rtl/core/pseudo_log_sum_derivatives.sv
bench/tb_top.sv
